// ===== rtl/set_assoc_cache_lru_lookup_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the cache lookup block
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_LRU_LOOKUP_TOP_MACROS_SVH
`define SET_ASSOC_CACHE_LRU_LOOKUP_TOP_MACROS_SVH

// same-cycle implication, disabled while in reset
`define SACL_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define SACL_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sacl_pkg.sv =====
// ----------------------------------------------------------------------------
// sacl_pkg
// Types and constants shared by the cache lookup block
// ----------------------------------------------------------------------------
package sacl_pkg;

  localparam int unsigned MAX_LINES_DEF   = 512;
  localparam int unsigned BLOCK_BYTES_DEF = 64;
  localparam int unsigned MAX_WAYS_DEF    = 8;

  localparam int unsigned ADDR_W       = 32;
  localparam int unsigned STAMP_W      = 32;
  localparam int unsigned CNT_W        = 32;
  localparam int unsigned LINES_LOG2_W = 4;
  localparam int unsigned WAYS_LOG2_W  = 2;
  localparam int unsigned CFG_ADDR_W   = 3;
  localparam int unsigned CFG_DATA_W   = 32;

  localparam logic [LINES_LOG2_W-1:0] LINES_LOG2_RST = LINES_LOG2_W'(4);
  localparam logic [WAYS_LOG2_W-1:0]  WAYS_LOG2_RST  = '0;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_LINES_LOG2,
    REG_WAYS_LOG2
  } cfg_reg_e;

  typedef struct packed {
    logic clear;
    logic accept;
    logic read;
    logic compare;
    logic min_step;
    logic update;
    logic load_out;
  } sacl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic need_min;
    logic out_free;
  } sacl_sts_t;

endpackage

// ===== rtl/sacl_if.sv =====
// ----------------------------------------------------------------------------
// sacl_if
// Valid/ready channels for lookup requests and lookup results
// ----------------------------------------------------------------------------
interface sacl_req_if import sacl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output address, input ready);
  modport sink (input valid, input address, output ready);
endinterface

interface sacl_rsp_if import sacl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             hit;
  logic [CNT_W-1:0] access_count;
  logic [CNT_W-1:0] miss_count;

  modport source (output valid, output hit, output access_count, output miss_count,
                  input ready);
  modport sink (input valid, input hit, input access_count, input miss_count,
                output ready);
endinterface

// ===== rtl/sacl_ram.sv =====
// ----------------------------------------------------------------------------
// sacl_ram
// Generic single-port RAM with registered read data
// ----------------------------------------------------------------------------
module sacl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/sacl_cfg.sv =====
// ----------------------------------------------------------------------------
// sacl_cfg
// APB register file holding the line count and associativity settings
// ----------------------------------------------------------------------------
module sacl_cfg import sacl_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CFG_ADDR_W-1:0]   paddr,
  input  logic [CFG_DATA_W-1:0]   pwdata,
  output logic [CFG_DATA_W-1:0]   prdata,
  output logic                    pready,
  output logic [LINES_LOG2_W-1:0] lines_log2_o,
  output logic [WAYS_LOG2_W-1:0]  ways_log2_o
);

  logic [LINES_LOG2_W-1:0] lines_log2_q;
  logic [WAYS_LOG2_W-1:0]  ways_log2_q;
  cfg_reg_e                reg_sel;
  logic                    wr_en;

  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_e'(paddr[2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lines_log2_q <= LINES_LOG2_RST;
      ways_log2_q  <= WAYS_LOG2_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_LINES_LOG2: lines_log2_q <= pwdata[LINES_LOG2_W-1:0];
        REG_WAYS_LOG2:  ways_log2_q  <= pwdata[WAYS_LOG2_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_LINES_LOG2: prdata = CFG_DATA_W'(lines_log2_q);
      REG_WAYS_LOG2:  prdata = CFG_DATA_W'(ways_log2_q);
      default:        prdata = '0;
    endcase
  end

  assign lines_log2_o = lines_log2_q;
  assign ways_log2_o  = ways_log2_q;

endmodule

// ===== rtl/sacl_ctrl.sv =====
// ----------------------------------------------------------------------------
// sacl_ctrl
// Lookup sequencer: clearing pass, row read, compare, victim search, result output after write back
// ----------------------------------------------------------------------------
module sacl_ctrl import sacl_pkg::*; #(
  parameter int unsigned MAX_WAYS = MAX_WAYS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  sacl_sts_t sts_i,
  output sacl_cmd_t cmd_o
);

  localparam int unsigned WAY_BITS = $clog2(MAX_WAYS);
  localparam int unsigned LVL_W    = $clog2(WAY_BITS + 2);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CMP,
    S_MIN,
    S_UPDATE,
    S_EMIT
  } state_e;

  state_e             state_q, state_d;
  logic [LVL_W-1:0]   lvl_q, lvl_d;
  logic               accept;

  always_comb begin
    in_ready_o = (state_q == S_IDLE) || ((state_q == S_EMIT) && sts_i.out_free);
    accept     = in_ready_o && in_valid_i;

    cmd_o          = '0;
    cmd_o.clear    = (state_q == S_CLEAR);
    cmd_o.accept   = accept;
    cmd_o.read     = (state_q == S_READ);
    cmd_o.compare  = (state_q == S_CMP);
    cmd_o.min_step = (state_q == S_MIN);
    cmd_o.update   = (state_q == S_UPDATE);
    cmd_o.load_out = (state_q == S_EMIT) && sts_i.out_free;
  end

  always_comb begin
    state_d = state_q;
    lvl_d   = lvl_q;
    unique case (state_q)
      S_CLEAR: begin
        if (sts_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = S_READ;
        end
      end
      S_READ: state_d = S_CMP;
      S_CMP: begin
        if (sts_i.need_min && (WAY_BITS > 0)) begin
          state_d = S_MIN;
          lvl_d   = LVL_W'(WAY_BITS);
        end else begin
          state_d = S_UPDATE;
        end
      end
      S_MIN: begin
        if (lvl_q == LVL_W'(1)) begin
          state_d = S_UPDATE;
        end else begin
          lvl_d = lvl_q - LVL_W'(1);
        end
      end
      S_UPDATE: state_d = S_EMIT;
      S_EMIT: begin
        if (sts_i.out_free) begin
          state_d = accept ? S_READ : S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      lvl_q   <= '0;
    end else begin
      state_q <= state_d;
      lvl_q   <= lvl_d;
    end
  end

endmodule

// ===== rtl/sacl_dp.sv =====
// ----------------------------------------------------------------------------
// sacl_dp
// Address split, way compare, oldest-stamp tree, row update and counters
// ----------------------------------------------------------------------------
`include "set_assoc_cache_lru_lookup_top_macros.svh"

module sacl_dp import sacl_pkg::*; #(
  parameter int unsigned MAX_LINES   = MAX_LINES_DEF,
  parameter int unsigned BLOCK_BYTES = BLOCK_BYTES_DEF,
  parameter int unsigned MAX_WAYS    = MAX_WAYS_DEF,
  localparam int unsigned OFF_BITS  = $clog2(BLOCK_BYTES),
  localparam int unsigned TAG_W     = ADDR_W - OFF_BITS,
  localparam int unsigned LINE_BITS = $clog2(MAX_LINES),
  localparam int unsigned WAY_BITS  = $clog2(MAX_WAYS),
  localparam int unsigned SLOT_W    = (WAY_BITS > 0) ? WAY_BITS : 1,
  localparam int unsigned ROWS      = MAX_LINES / MAX_WAYS,
  localparam int unsigned ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1,
  localparam int unsigned ENT_W     = 1 + TAG_W + STAMP_W,
  localparam int unsigned RAM_W     = MAX_WAYS * ENT_W
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  sacl_cmd_t               cmd_i,
  output sacl_sts_t               sts_o,
  input  logic [LINES_LOG2_W-1:0] lines_log2_i,
  input  logic [WAYS_LOG2_W-1:0]  ways_log2_i,
  input  logic [ADDR_W-1:0]       in_address_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    out_hit_o,
  output logic [CNT_W-1:0]        out_access_count_o,
  output logic [CNT_W-1:0]        out_miss_count_o,
  output logic                    ram_we_o,
  output logic                    ram_re_o,
  output logic [ROW_W-1:0]        ram_addr_o,
  output logic [RAM_W-1:0]        ram_wdata_o,
  input  logic [RAM_W-1:0]        ram_rdata_i
);

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + CNT_W'(1);
  endfunction

  // address split
  logic [LINES_LOG2_W-1:0] lg_lines, lg_ways, idx_bits;
  logic [TAG_W-1:0]        block, tag_d;
  logic [LINE_BITS-1:0]    set_mask, base;
  logic [SLOT_W-1:0]       base_slot;
  logic [ROW_W-1:0]        row_d;
  logic [MAX_WAYS-1:0]     member_d;

  logic [TAG_W-1:0]        tag_q;
  logic [ROW_W-1:0]        row_q;
  logic [MAX_WAYS-1:0]     member_q;

  // row read back
  logic                    rd_valid [MAX_WAYS];
  logic [TAG_W-1:0]        rd_tag [MAX_WAYS];
  logic [STAMP_W-1:0]      rd_stamp [MAX_WAYS];
  logic                    any_match, any_free;
  logic [SLOT_W-1:0]       match_slot, free_slot;

  logic                    row_valid_q [MAX_WAYS];
  logic [TAG_W-1:0]        row_tag_q [MAX_WAYS];
  logic [STAMP_W-1:0]      row_stamp_q [MAX_WAYS];
  logic                    hit_q, free_q;
  logic [SLOT_W-1:0]       hit_slot_q, free_slot_q;

  // oldest-stamp tree
  logic                    cand_ok_q [MAX_WAYS];
  logic [STAMP_W-1:0]      cand_stamp_q [MAX_WAYS];
  logic [SLOT_W-1:0]       cand_slot_q [MAX_WAYS];

  // update and counters
  logic [SLOT_W-1:0]       victim;
  logic [CNT_W-1:0]        acc_q, miss_q, acc_inc;
  logic [RAM_W-1:0]        wr_row;
  logic [ROW_W-1:0]        clr_row_q;

  logic                    out_valid_q, out_hit_q;
  logic [CNT_W-1:0]        out_acc_q, out_miss_q;

  always_comb begin
    lg_lines = (lines_log2_i > LINES_LOG2_W'(LINE_BITS)) ? LINES_LOG2_W'(LINE_BITS)
                                                          : lines_log2_i;
    lg_ways = LINES_LOG2_W'(ways_log2_i);
    if (lg_ways > LINES_LOG2_W'(WAY_BITS)) begin
      lg_ways = LINES_LOG2_W'(WAY_BITS);
    end
    if (lg_ways > lg_lines) begin
      lg_ways = lg_lines;
    end
    idx_bits  = lg_lines - lg_ways;
    block     = in_address_i[ADDR_W-1:OFF_BITS];
    // set index from the low block bits, first line of the set above it
    set_mask  = ~({LINE_BITS{1'b1}} << idx_bits);
    base      = (block[LINE_BITS-1:0] & set_mask) << lg_ways;
    base_slot = SLOT_W'(base & LINE_BITS'(MAX_WAYS - 1));
    row_d     = ROW_W'(base >> WAY_BITS);
    tag_d     = block >> idx_bits;
    for (int k = 0; k < MAX_WAYS; k++) begin
      member_d[k] = ((SLOT_W'(k) ^ base_slot) >> lg_ways) == '0;
    end
  end

  always_comb begin
    any_match  = 1'b0;
    any_free   = 1'b0;
    match_slot = '0;
    free_slot  = '0;
    for (int k = 0; k < MAX_WAYS; k++) begin
      rd_stamp[k] = ram_rdata_i[k*ENT_W +: STAMP_W];
      rd_tag[k]   = ram_rdata_i[k*ENT_W + STAMP_W +: TAG_W];
      rd_valid[k] = ram_rdata_i[k*ENT_W + STAMP_W + TAG_W];
      if (member_q[k] && rd_valid[k] && (rd_tag[k] == tag_q) && !any_match) begin
        any_match  = 1'b1;
        match_slot = SLOT_W'(k);
      end
      if (member_q[k] && !rd_valid[k] && !any_free) begin
        any_free  = 1'b1;
        free_slot = SLOT_W'(k);
      end
    end
  end

  always_comb begin
    acc_inc = sat_inc(acc_q);
    if (hit_q) begin
      victim = hit_slot_q;
    end else if (free_q) begin
      victim = free_slot_q;
    end else begin
      victim = cand_slot_q[0];
    end
    for (int k = 0; k < MAX_WAYS; k++) begin
      if (SLOT_W'(k) == victim) begin
        wr_row[k*ENT_W +: ENT_W] = {1'b1, tag_q, acc_inc};
      end else begin
        wr_row[k*ENT_W +: ENT_W] = {row_valid_q[k], row_tag_q[k], row_stamp_q[k]};
      end
    end
  end

  assign ram_re_o    = cmd_i.read;
  assign ram_we_o    = cmd_i.clear || cmd_i.update;
  assign ram_addr_o  = cmd_i.clear ? clr_row_q : row_q;
  assign ram_wdata_o = cmd_i.clear ? '0 : wr_row;

  assign sts_o.clear_last = (clr_row_q == ROW_W'(ROWS - 1));
  assign sts_o.need_min   = !any_match && !any_free;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      tag_q    <= tag_d;
      row_q    <= row_d;
      member_q <= member_d;
    end
    if (cmd_i.compare) begin
      hit_q       <= any_match;
      free_q      <= any_free;
      hit_slot_q  <= match_slot;
      free_slot_q <= free_slot;
      for (int k = 0; k < MAX_WAYS; k++) begin
        row_valid_q[k]  <= rd_valid[k];
        row_tag_q[k]    <= rd_tag[k];
        row_stamp_q[k]  <= rd_stamp[k];
        cand_ok_q[k]    <= member_q[k];
        cand_stamp_q[k] <= rd_stamp[k];
        cand_slot_q[k]  <= SLOT_W'(k);
      end
    end else if (cmd_i.min_step) begin
      for (int j = 0; j < MAX_WAYS / 2; j++) begin
        if (cand_ok_q[2*j] &&
            (!cand_ok_q[2*j+1] || (cand_stamp_q[2*j] <= cand_stamp_q[2*j+1]))) begin
          cand_ok_q[j]    <= cand_ok_q[2*j];
          cand_stamp_q[j] <= cand_stamp_q[2*j];
          cand_slot_q[j]  <= cand_slot_q[2*j];
        end else begin
          cand_ok_q[j]    <= cand_ok_q[2*j+1];
          cand_stamp_q[j] <= cand_stamp_q[2*j+1];
          cand_slot_q[j]  <= cand_slot_q[2*j+1];
        end
      end
    end
    if (cmd_i.load_out) begin
      out_hit_q  <= hit_q;
      out_acc_q  <= acc_q;
      out_miss_q <= miss_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      miss_q      <= '0;
      clr_row_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.update) begin
        acc_q <= acc_inc;
        if (!hit_q) begin
          miss_q <= sat_inc(miss_q);
        end
      end
      if (cmd_i.clear) begin
        clr_row_q <= clr_row_q + ROW_W'(1);
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_hit_o          = out_hit_q;
  assign out_access_count_o = out_acc_q;
  assign out_miss_count_o   = out_miss_q;

  `SACL_ASSERT_NEXT(a_acc_step, clk_i, rst_ni, cmd_i.update && (acc_q != '1),
                    acc_q == $past(acc_q) + CNT_W'(1), "access count did not advance")
  `SACL_ASSERT_NEXT(a_hit_keeps_miss, clk_i, rst_ni, cmd_i.update && hit_q,
                    miss_q == $past(miss_q), "miss count moved on a hit")
  `SACL_ASSERT_NOW(a_victim_member, clk_i, rst_ni, cmd_i.update && !hit_q && !free_q,
                   cand_ok_q[0] && member_q[cand_slot_q[0]], "replacement way outside the set")
  `SACL_ASSERT_NOW(a_hit_valid, clk_i, rst_ni, cmd_i.update && hit_q,
                   row_valid_q[hit_slot_q] && member_q[hit_slot_q],
                   "hit on an invalid or foreign way")

endmodule

// ===== rtl/set_assoc_cache_lru_lookup_top.sv =====
// each request: row read, compare, a step through each level of the oldest-stamp
//   compare tree when a valid way is replaced, row write back and result load; one row
//   read and one row write on the single-port line RAM per lookup; one lookup at a time,
//   the next request taken as the result loads, which waits while the receiver stalls
// reset: counters cleared, then a clearing pass over all MAX_LINES/MAX_WAYS RAM rows
//   (one RAM row per cycle) before the first request is taken
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_lookup_top
// Set-associative cache lookup with least-recently-used replacement
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_lookup_top import sacl_pkg::*; #(
  parameter int unsigned MAX_LINES   = MAX_LINES_DEF,
  parameter int unsigned BLOCK_BYTES = BLOCK_BYTES_DEF,
  parameter int unsigned MAX_WAYS    = MAX_WAYS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  sacl_req_if.sink              req,
  sacl_rsp_if.source            rsp,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned TAG_W = ADDR_W - $clog2(BLOCK_BYTES);
  localparam int unsigned ROWS  = MAX_LINES / MAX_WAYS;
  localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned RAM_W = MAX_WAYS * (1 + TAG_W + STAMP_W);

  logic [LINES_LOG2_W-1:0] lines_log2;
  logic [WAYS_LOG2_W-1:0]  ways_log2;
  sacl_cmd_t               cmd;
  sacl_sts_t               sts;
  logic                    ram_we, ram_re;
  logic [ROW_W-1:0]        ram_addr;
  logic [RAM_W-1:0]        ram_wdata, ram_rdata;

  sacl_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .lines_log2_o (lines_log2),
    .ways_log2_o  (ways_log2)
  );

  sacl_ctrl #(
    .MAX_WAYS (MAX_WAYS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req.valid),
    .in_ready_o (req.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sacl_dp #(
    .MAX_LINES   (MAX_LINES),
    .BLOCK_BYTES (BLOCK_BYTES),
    .MAX_WAYS    (MAX_WAYS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .lines_log2_i       (lines_log2),
    .ways_log2_i        (ways_log2),
    .in_address_i       (req.address),
    .out_valid_o        (rsp.valid),
    .out_ready_i        (rsp.ready),
    .out_hit_o          (rsp.hit),
    .out_access_count_o (rsp.access_count),
    .out_miss_count_o   (rsp.miss_count),
    .ram_we_o           (ram_we),
    .ram_re_o           (ram_re),
    .ram_addr_o         (ram_addr),
    .ram_wdata_o        (ram_wdata),
    .ram_rdata_i        (ram_rdata)
  );

  sacl_ram #(
    .WIDTH (RAM_W),
    .DEPTH (ROWS)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Runs address lookups through the cache block and checks hit flags and the
// access and miss counts against a behavioral set-associative cache with
// least-recently-used replacement, over several geometries and under random
// sender gaps, receiver stalls and one long receiver hold-off
// ----------------------------------------------------------------------------
module tb;
  import sacl_pkg::*;

  localparam int unsigned OFFSET_BITS = $clog2(BLOCK_BYTES_DEF);
  localparam int unsigned LINES_CAP   = $clog2(MAX_LINES_DEF);
  localparam int unsigned WAYS_CAP    = $clog2(MAX_WAYS_DEF);
  localparam int unsigned TAG_W       = ADDR_W - OFFSET_BITS;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned DRAIN_WAIT  = 8;
  localparam int unsigned PHASE_ITEMS = 150;
  localparam int unsigned NUM_PHASES  = 8;

  typedef enum logic {
    ROW_LOOKUP,
    ROW_CONFIG
  } row_kind_e;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct packed {
    logic             hit;
    logic [CNT_W-1:0] access_count;
    logic [CNT_W-1:0] miss_count;
  } lookup_t;

  typedef struct packed {
    row_kind_e   kind;
    cfg_reg_e    target;
    logic [31:0] data;
    logic        typed;
    lookup_t     want;
  } row_t;

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  sacl_req_if req_ch ();
  sacl_rsp_if rsp_ch ();

  set_assoc_cache_lru_lookup_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // behavioral cache
  logic                    way_valid [MAX_LINES_DEF];
  logic [TAG_W-1:0]        way_tag   [MAX_LINES_DEF];
  logic [STAMP_W-1:0]      way_stamp [MAX_LINES_DEF];
  logic [CNT_W-1:0]        n_access;
  logic [CNT_W-1:0]        n_miss;
  logic [LINES_LOG2_W-1:0] cfg_lines;
  logic [WAYS_LOG2_W-1:0]  cfg_ways;

  lookup_t     expected_lookups [$];
  row_t        directed_rows [$];
  int unsigned failures = 0;
  int unsigned send_gap_pct = 0;
  int unsigned resp_stall_pct = 0;
  int unsigned hold_left = 0;
  bit          hold_request = 0;
  bit          hold_done = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic void geometry(output int unsigned lg_lines, output int unsigned lg_ways);
    lg_lines = 32'(cfg_lines);
    if (lg_lines > LINES_CAP) lg_lines = LINES_CAP;
    lg_ways = 32'(cfg_ways);
    if (lg_ways > WAYS_CAP) lg_ways = WAYS_CAP;
    if (lg_ways > lg_lines) lg_ways = lg_lines;
  endfunction

  function automatic lookup_t cache_lookup(input logic [ADDR_W-1:0] addr);
    int unsigned lg_lines, lg_ways, idx_bits, nways, base, line, victim, w;
    logic [TAG_W-1:0]   blk, set_idx, tg;
    logic [STAMP_W-1:0] oldest;
    logic               found, free;
    lookup_t            r;
    geometry(lg_lines, lg_ways);
    idx_bits = lg_lines - lg_ways;
    nways = 1 << lg_ways;
    blk = addr[ADDR_W-1:OFFSET_BITS];
    set_idx = blk & ((TAG_W'(1) << idx_bits) - TAG_W'(1));
    tg = blk >> idx_bits;
    base = 32'(set_idx) << lg_ways;
    if (n_access != '1) n_access = n_access + 1;
    found = 1'b0;
    for (w = 0; w < nways && !found; w++) begin
      line = (base + w) % MAX_LINES_DEF;
      if (way_valid[line] && way_tag[line] == tg) begin
        found = 1'b1;
        way_stamp[line] = n_access;
      end
    end
    if (!found) begin
      if (n_miss != '1) n_miss = n_miss + 1;
      victim = 0;
      free = 1'b0;
      for (w = 0; w < nways && !free; w++) begin
        if (!way_valid[(base + w) % MAX_LINES_DEF]) begin
          victim = w;
          free = 1'b1;
        end
      end
      if (!free) begin
        oldest = way_stamp[base % MAX_LINES_DEF];
        for (w = 1; w < nways; w++) begin
          line = (base + w) % MAX_LINES_DEF;
          if (way_stamp[line] < oldest) begin
            oldest = way_stamp[line];
            victim = w;
          end
        end
      end
      line = (base + victim) % MAX_LINES_DEF;
      way_valid[line] = 1'b1;
      way_tag[line] = tg;
      way_stamp[line] = n_access;
    end
    r.hit = found;
    r.access_count = n_access;
    r.miss_count = n_miss;
    return r;
  endfunction

  // mostly a few hot sets with a handful of tags, some fully random addresses
  function automatic logic [ADDR_W-1:0] pick_address();
    int unsigned lg_lines, lg_ways, idx_bits, nsets, nways, set_sel, tg;
    logic [TAG_W-1:0] blk;
    geometry(lg_lines, lg_ways);
    idx_bits = lg_lines - lg_ways;
    nsets = 1 << idx_bits;
    nways = 1 << lg_ways;
    if ($urandom_range(0, 99) < 15) return $urandom;
    case ($urandom_range(0, 3))
      0: set_sel = 0;
      1: set_sel = 1 % nsets;
      2: set_sel = nsets - 1;
      default: set_sel = $urandom_range(0, nsets - 1);
    endcase
    tg = $urandom_range(0, nways + 1);
    blk = (TAG_W'(tg) << idx_bits) | TAG_W'(set_sel);
    return {blk, OFFSET_BITS'($urandom)};
  endfunction

  function automatic void add_row(input row_kind_e kind, input cfg_reg_e target,
                                  input logic [31:0] data, input logic typed,
                                  input logic hit, input logic [CNT_W-1:0] acc,
                                  input logic [CNT_W-1:0] miss);
    row_t r;
    r.kind = kind;
    r.target = target;
    r.data = data;
    r.typed = typed;
    r.want.hit = hit;
    r.want.access_count = acc;
    r.want.miss_count = miss;
    directed_rows.push_back(r);
  endfunction

  task automatic offer_lookup(input logic [ADDR_W-1:0] addr, input logic typed,
                              input lookup_t want);
    lookup_t predicted;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.address <= addr;
    do @(posedge clk_i); while (!req_ch.ready);
    predicted = cache_lookup(addr);
    expected_lookups.push_back(typed ? want : predicted);
    @(negedge clk_i);
  endtask

  task automatic drain_lookups();
    req_ch.valid <= 1'b0;
    while (expected_lookups.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic program_reg(input cfg_reg_e target, input logic [31:0] data);
    logic [CFG_DATA_W-1:0] readback;
    readback = (target == REG_LINES_LOG2) ? CFG_DATA_W'(data[LINES_LOG2_W-1:0])
                                          : CFG_DATA_W'(data[WAYS_LOG2_W-1:0]);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {target, 2'b00};
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (target == REG_LINES_LOG2) cfg_lines = data[LINES_LOG2_W-1:0];
    else cfg_ways = data[WAYS_LOG2_W-1:0];
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== readback) begin
      $error("%s: expected %0d, got %0d", target.name(), readback, prdata);
      failures++;
    end
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(negedge clk_i) begin
    if (hold_request && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1;
    end
    if (hold_left != 0) begin
      rsp_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= resp_stall_pct);
    end
  end

  always @(posedge clk_i) begin : result_check
    lookup_t want;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_lookups.size() == 0) begin
        $error("result transaction with no lookup outstanding");
        failures++;
      end else begin
        want = expected_lookups.pop_front();
        if (rsp_ch.hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, rsp_ch.hit);
          failures++;
        end
        if (rsp_ch.access_count !== want.access_count) begin
          $error("access_count: expected %0d, got %0d", want.access_count,
                 rsp_ch.access_count);
          failures++;
        end
        if (rsp_ch.miss_count !== want.miss_count) begin
          $error("miss_count: expected %0d, got %0d", want.miss_count, rsp_ch.miss_count);
          failures++;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (psel && penable)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("set_assoc_cache_lru_lookup_top: mismatch");
    $finish;
  end

  initial begin : stimulus
    lookup_t     none;
    idle_mode_e  mode;
    int unsigned lines, ways;
    none = '0;
    req_ch.valid = 1'b0;
    req_ch.address = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    foreach (way_valid[i]) way_valid[i] = 1'b0;
    n_access = '0;
    n_miss = '0;
    cfg_lines = LINES_LOG2_RST;
    cfg_ways = WAYS_LOG2_RST;

    // direct-mapped, 16 sets after reset
    add_row(ROW_LOOKUP, REG_LINES_LOG2, 32'h0000_0000, 1'b1, 1'b0, 1, 1);
    add_row(ROW_LOOKUP, REG_LINES_LOG2, 32'h0000_003F, 1'b1, 1'b1, 2, 1);
    add_row(ROW_LOOKUP, REG_LINES_LOG2, 32'hFFFF_FFFF, 1'b1, 1'b0, 3, 2);
    add_row(ROW_LOOKUP, REG_LINES_LOG2, 32'hFFFF_FFC0, 1'b1, 1'b1, 4, 2);
    add_row(ROW_LOOKUP, REG_LINES_LOG2, 32'h0000_0400, 1'b1, 1'b0, 5, 3);
    add_row(ROW_LOOKUP, REG_LINES_LOG2, 32'h0000_0000, 1'b1, 1'b0, 6, 4);
    // four ways over the old contents, hit refresh then eviction
    add_row(ROW_CONFIG, REG_WAYS_LOG2,  32'hFFFF_FFFE, 1'b0, 1'b0, 0, 0);
    add_row(ROW_LOOKUP, REG_LINES_LOG2, 32'h0000_0000, 1'b0, 1'b0, 0, 0);
    add_row(ROW_LOOKUP, REG_LINES_LOG2, 32'h0000_0100, 1'b0, 1'b0, 0, 0);
    add_row(ROW_LOOKUP, REG_LINES_LOG2, 32'h0000_0200, 1'b0, 1'b0, 0, 0);
    add_row(ROW_LOOKUP, REG_LINES_LOG2, 32'h0000_0300, 1'b0, 1'b0, 0, 0);
    add_row(ROW_LOOKUP, REG_LINES_LOG2, 32'h0000_0100, 1'b0, 1'b0, 0, 0);
    add_row(ROW_LOOKUP, REG_LINES_LOG2, 32'h0000_0400, 1'b0, 1'b0, 0, 0);
    add_row(ROW_LOOKUP, REG_LINES_LOG2, 32'h0000_0200, 1'b0, 1'b0, 0, 0);
    // line count above the maximum
    add_row(ROW_CONFIG, REG_LINES_LOG2, 32'hFFFF_FFFF, 1'b0, 1'b0, 0, 0);
    add_row(ROW_CONFIG, REG_WAYS_LOG2,  32'h0000_0003, 1'b0, 1'b0, 0, 0);
    add_row(ROW_LOOKUP, REG_LINES_LOG2, 32'h7FFF_FFC0, 1'b0, 1'b0, 0, 0);
    add_row(ROW_LOOKUP, REG_LINES_LOG2, 32'h0000_8000, 1'b0, 1'b0, 0, 0);
    // a single line, ways clipped to it
    add_row(ROW_CONFIG, REG_LINES_LOG2, 32'h0000_0010, 1'b0, 1'b0, 0, 0);
    add_row(ROW_LOOKUP, REG_LINES_LOG2, 32'h0000_0040, 1'b0, 1'b0, 0, 0);
    add_row(ROW_LOOKUP, REG_LINES_LOG2, 32'h0000_0040, 1'b0, 1'b0, 0, 0);
    add_row(ROW_LOOKUP, REG_LINES_LOG2, 32'h0000_0080, 1'b0, 1'b0, 0, 0);
    // one fully associative set of four lines
    add_row(ROW_CONFIG, REG_LINES_LOG2, 32'h0000_0002, 1'b0, 1'b0, 0, 0);
    add_row(ROW_LOOKUP, REG_LINES_LOG2, 32'h0000_00C0, 1'b0, 1'b0, 0, 0);
    add_row(ROW_LOOKUP, REG_LINES_LOG2, 32'h0000_0040, 1'b0, 1'b0, 0, 0);
    add_row(ROW_LOOKUP, REG_LINES_LOG2, 32'h8000_0000, 1'b0, 1'b0, 0, 0);
    add_row(ROW_LOOKUP, REG_LINES_LOG2, 32'h0000_0040, 1'b0, 1'b0, 0, 0);

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CONFIG) begin
        drain_lookups();
        program_reg(directed_rows[i].target, directed_rows[i].data);
      end else begin
        offer_lookup(directed_rows[i].data, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin lines = 9;  ways = 3; mode = IDLE_NONE; end
        1: begin lines = 4;  ways = 0; mode = IDLE_SEND; end
        2: begin lines = 0;  ways = 0; mode = IDLE_RECV; end
        3: begin lines = 15; ways = 3; mode = IDLE_BOTH; end
        4: begin lines = 2;  ways = 3; mode = IDLE_NONE; end
        5: begin lines = 6;  ways = 1; mode = IDLE_SEND; end
        6: begin lines = 9;  ways = 0; mode = IDLE_RECV; end
        default: begin
          lines = $urandom_range(0, 15);
          ways = $urandom_range(0, 3);
          mode = IDLE_BOTH;
        end
      endcase
      drain_lookups();
      program_reg(REG_LINES_LOG2, {28'($urandom), 4'(lines)});
      program_reg(REG_WAYS_LOG2, {30'($urandom), 2'(ways)});
      case (mode)
        IDLE_NONE: begin send_gap_pct = 0;  resp_stall_pct = 0;  end
        IDLE_SEND: begin send_gap_pct = 71; resp_stall_pct = 0;  end
        IDLE_RECV: begin send_gap_pct = 0;  resp_stall_pct = 71; end
        default:   begin send_gap_pct = 20; resp_stall_pct = 20; end
      endcase
      if (phase == 0) hold_request = 1;
      repeat (PHASE_ITEMS) offer_lookup(pick_address(), 1'b0, none);
    end

    drain_lookups();
    if (expected_lookups.size() != 0) begin
      $error("%0d lookups without a result", expected_lookups.size());
      failures++;
    end
    if (failures == 0) begin
      $display("set_assoc_cache_lru_lookup_top: match");
    end else begin
      $display("set_assoc_cache_lru_lookup_top: mismatch");
    end
    $finish;
  end

endmodule
